### design/timer_deadline_coarse_rounding_assert.svh
// assertion macros shared by the deadline rounding block
`ifndef TIMER_DEADLINE_COARSE_ROUNDING_ASSERT_SVH
`define TIMER_DEADLINE_COARSE_ROUNDING_ASSERT_SVH

// same-cycle implication, muted while reset is high
`define TDCR_CHECK_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define TDCR_CHECK_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) (cond) |=> (conseq)) \
      else $error(msg);

`endif

### design/tdcr_pkg.sv
package tdcr_pkg;

   // seconds are carried unwrapped with two spare bits
   localparam int SEC_BITS = 32;
   localparam int SEC_W    = SEC_BITS + 2;

   localparam logic [19:0] USEC_MAX           = 20'd999999;
   localparam logic [20:0] USEC_PER_SEC       = 21'd1000000;
   localparam logic [19:0] HALF_SEC_USEC      = 20'd500000;
   localparam logic [30:0] VERY_COARSE_MIN_MS = 31'd20000;
   localparam logic [30:0] PRECISE_MAX_MS     = 31'd20;
   localparam logic [30:0] ONE_SEC_MS         = 31'd1000;
   localparam logic [14:0] LONG_HALF_SEC_MS   = 15'd5000;
   localparam logic [14:0] SMALL_IVL_MS       = 15'd100;
   localparam logic [14:0] TINY_IVL_MS        = 15'd50;
   localparam logic [10:0] MS_PER_SEC         = 11'd1000;
   localparam logic [10:0] HALF_MS_PER_SEC    = 11'd500;
   localparam logic signed [45:0] RESYNC_SHORT_MS = 46'sd1500;

   // reciprocals for constant division, ceil(2^k / d)
   localparam longint unsigned RCP_1000_U31 = ((64'd1 << 41) + 64'd999) / 64'd1000;
   localparam longint unsigned RCP_1000_U20 = ((64'd1 << 30) + 64'd999) / 64'd1000;
   localparam longint unsigned RCP_20_U15   = ((64'd1 << 24) + 64'd19) / 64'd20;
   localparam longint unsigned RCP_25_U15   = ((64'd1 << 24) + 64'd24) / 64'd25;
   localparam longint unsigned RCP_50_U15   = ((64'd1 << 24) + 64'd49) / 64'd50;
   localparam longint unsigned RCP_250_U15  = ((64'd1 << 24) + 64'd249) / 64'd250;
   localparam longint unsigned RCP_500_U15  = ((64'd1 << 24) + 64'd499) / 64'd500;
   localparam longint unsigned RCP_25_U10   = ((64'd1 << 20) + 64'd24) / 64'd25;
   localparam longint unsigned RCP_50_U10   = ((64'd1 << 20) + 64'd49) / 64'd50;
   localparam longint unsigned RCP_100_U10  = ((64'd1 << 20) + 64'd99) / 64'd100;
   localparam longint unsigned RCP_200_U10  = ((64'd1 << 20) + 64'd199) / 64'd200;
   localparam longint unsigned RCP_250_U10  = ((64'd1 << 20) + 64'd249) / 64'd250;
   localparam longint unsigned RCP_500_U10  = ((64'd1 << 20) + 64'd499) / 64'd500;

   typedef enum logic [1:0] {
      KIND_PRECISE    = 2'd0,
      KIND_COARSE     = 2'd1,
      KIND_VCOARSE    = 2'd2,
      KIND_COARSE_ALT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RND_TWO   = 2'd0,
      RND_FOUR  = 2'd1,
      RND_SPLIT = 2'd2,
      RND_STEP  = 2'd3
   } rnd_type;

   typedef enum logic [2:0] {
      STEP_25  = 3'd0,
      STEP_50  = 3'd1,
      STEP_100 = 3'd2,
      STEP_200 = 3'd3,
      STEP_250 = 3'd4,
      STEP_500 = 3'd5
   } step_type;

   typedef struct packed {
      logic [SEC_W-1:0] s;
      logic [19:0]      u;
   } time_type;

   typedef struct packed {
      kind_type    kind;
      logic [30:0] ivl;
      logic [31:0] now_s;
      logic [19:0] now_u;
      logic [31:0] prev_s;
      logic [19:0] prev_u;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [30:0] ivl;
      logic [21:0] q;
      logic [9:0]  r;
      time_type    now;
      time_type    ddl;
      logic [9:0]  slack;
      rnd_type     rmode;
      step_type    step;
   } sched_type;

   typedef struct packed {
      time_type now;
      time_type ddl;
   } fin_type;

   function automatic logic [21:0] div1000_u31(logic [30:0] x);
      logic [62:0] p;
      p = 63'(x) * 63'(RCP_1000_U31);
      return p[62:41];
   endfunction

   function automatic logic [9:0] div1000_u20(logic [19:0] x);
      logic [40:0] p;
      p = 41'(x) * 41'(RCP_1000_U20);
      return p[39:30];
   endfunction

   function automatic logic [10:0] quot_u15(logic [14:0] x, logic [19:0] rcp);
      logic [34:0] p;
      p = 35'(x) * 35'(rcp);
      return p[34:24];
   endfunction

   function automatic logic [5:0] quot_u10(logic [9:0] x, logic [15:0] rcp);
      logic [25:0] p;
      p = 26'(x) * 26'(rcp);
      return p[25:20];
   endfunction

   // add whole seconds q and leftover milliseconds r
   function automatic time_type time_add(time_type t, logic [21:0] q, logic [9:0] r);
      logic [SEC_W-1:0] s;
      logic [20:0]      u;
      time_type         res;
      s = t.s + SEC_W'(q);
      u = 21'(t.u) + 21'(r) * 21'd1000;
      if (u > 21'(USEC_MAX)) begin
         s = s + SEC_W'(1);
         u = u - USEC_PER_SEC;
      end
      res.s = s;
      res.u = u[19:0];
      return res;
   endfunction

   function automatic logic time_lt(time_type a, time_type b);
      return (a.s < b.s) || ((a.s == b.s) && (a.u < b.u));
   endfunction

endpackage

### design/tdcr_prep.sv
module tdcr_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  tdcr_pkg::req_type   up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output tdcr_pkg::sched_type dn_data
);
   import tdcr_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [30:0] ivl;
      logic [21:0] q;
      time_type    now;
      time_type    prev;
      logic [9:0]  now_ms;
      logic [9:0]  prev_ms;
   } prep_a_type;

   prep_a_type a_in, a_ff;
   logic       a_valid_ff, a_rdy;
   sched_type  b_in, b_ff;
   logic       b_valid_ff, b_rdy;

   logic [19:0]        nu, wu;
   logic signed [32:0] ds;
   logic signed [45:0] ahead, lhs, rhs;
   logic               resync;
   logic [14:0]        ivl15, rem25, rem50, rem250, rem500;
   logic [10:0]        q20, q25, q50, q250, q500;

   assign a_rdy    = !a_valid_ff || b_rdy;
   assign b_rdy    = !b_valid_ff || dn_ready;
   assign up_ready = a_rdy;
   assign dn_valid = b_valid_ff;
   assign dn_data  = b_ff;

   // stage a: clamp, kind promotion, interval split and ms of each time
   always_comb begin
      nu = (up_data.now_u > USEC_MAX) ? USEC_MAX : up_data.now_u;
      wu = (up_data.prev_u > USEC_MAX) ? USEC_MAX : up_data.prev_u;
      a_in.ivl = up_data.ivl;
      if (up_data.kind == KIND_PRECISE || up_data.kind == KIND_VCOARSE) begin
         a_in.kind = up_data.kind;
      end else if (up_data.ivl >= VERY_COARSE_MIN_MS) begin
         a_in.kind = KIND_VCOARSE;
      end else if (up_data.ivl <= PRECISE_MAX_MS) begin
         a_in.kind = KIND_PRECISE;
      end else begin
         a_in.kind = KIND_COARSE;
      end
      a_in.q       = div1000_u31(up_data.ivl);
      a_in.now.s   = SEC_W'(up_data.now_s);
      a_in.now.u   = nu;
      a_in.prev.s  = SEC_W'(up_data.prev_s);
      a_in.prev.u  = wu;
      a_in.now_ms  = div1000_u20(nu);
      a_in.prev_ms = div1000_u20(wu);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_rdy) begin
         a_valid_ff <= up_valid;
      end
      if (a_rdy) begin
         a_ff <= a_in;
      end
   end

   // stage b: resync of a far deadline and coarse rounding setup
   always_comb begin
      ds    = $signed({1'b0, a_ff.prev.s[SEC_BITS-1:0]}) - $signed({1'b0, a_ff.now.s[SEC_BITS-1:0]});
      ahead = 46'(ds) * 46'sd1000 + $signed({36'd0, a_ff.prev_ms})
              - $signed({36'd0, a_ff.now_ms});
      lhs   = (ahead <<< 2) + ahead;
      rhs   = $signed({15'd0, a_ff.ivl}) * 46'sd6;
      resync = (a_ff.ivl != 31'd0) &&
               (((a_ff.ivl < ONE_SEC_MS) && (ahead > RESYNC_SHORT_MS)) ||
                ((a_ff.ivl >= ONE_SEC_MS) && (lhs > rhs)));

      ivl15  = a_ff.ivl[14:0];
      q20    = quot_u15(ivl15, 20'(RCP_20_U15));
      q25    = quot_u15(ivl15, 20'(RCP_25_U15));
      q50    = quot_u15(ivl15, 20'(RCP_50_U15));
      q250   = quot_u15(ivl15, 20'(RCP_250_U15));
      q500   = quot_u15(ivl15, 20'(RCP_500_U15));
      rem25  = ivl15 - 15'(q25) * 15'd25;
      rem50  = ivl15 - 15'(q50) * 15'd50;
      rem250 = ivl15 - 15'(q250) * 15'd250;
      rem500 = ivl15 - 15'(q500) * 15'd500;

      b_in.kind  = a_ff.kind;
      b_in.ivl   = a_ff.ivl;
      b_in.q     = a_ff.q;
      b_in.r     = 10'(a_ff.ivl - 31'(a_ff.q) * 31'd1000);
      b_in.now   = a_ff.now;
      b_in.ddl   = resync ? a_ff.now : a_ff.prev;
      b_in.slack = q20[9:0];
      b_in.step  = STEP_25;
      if ((ivl15 < SMALL_IVL_MS) && (rem25 != 15'd0)) begin
         b_in.rmode = (ivl15 < TINY_IVL_MS) ? RND_TWO : RND_FOUR;
      end else if (rem500 == 15'd0) begin
         b_in.rmode = (ivl15 >= LONG_HALF_SEC_MS) ? RND_SPLIT : RND_STEP;
         b_in.step  = STEP_500;
      end else if (rem50 == 15'd0) begin
         b_in.rmode = RND_STEP;
         if (q50[1:0] == 2'd0) begin
            b_in.step = STEP_200;
         end else if (!q50[0]) begin
            b_in.step = STEP_100;
         end else if (rem250 == 15'd0) begin
            b_in.step = STEP_250;
         end else begin
            b_in.step = STEP_50;
         end
      end else begin
         b_in.rmode = RND_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_rdy) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_rdy) begin
         b_ff <= b_in;
      end
   end

endmodule

### design/tdcr_step.sv
module tdcr_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  tdcr_pkg::sched_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output tdcr_pkg::sched_type dn_data
);
   import tdcr_pkg::*;

   sched_type        c_in, c_ff;
   logic             c_valid_ff, c_rdy;
   time_type         adv, nadv;
   logic [SEC_W-1:0] vs;

   assign c_rdy    = !c_valid_ff || dn_ready;
   assign up_ready = c_rdy;
   assign dn_valid = c_valid_ff;
   assign dn_data  = c_ff;

   // advance by one interval, per timer kind
   always_comb begin
      adv  = time_add(up_data.ddl, up_data.q, up_data.r);
      nadv = time_add(up_data.now, up_data.q, up_data.r);
      vs   = up_data.ddl.s + SEC_W'(up_data.ddl.u >= HALF_SEC_USEC) + SEC_W'(up_data.q);
      c_in = up_data;
      case (up_data.kind)
         KIND_VCOARSE: begin
            c_in.ddl.s = (vs <= up_data.now.s) ? up_data.now.s + SEC_W'(up_data.q) : vs;
            c_in.ddl.u = 20'd0;
         end
         KIND_PRECISE: begin
            if (up_data.ivl == 31'd0) begin
               c_in.ddl = up_data.now;
            end else begin
               c_in.ddl = time_lt(adv, up_data.now) ? nadv : adv;
            end
         end
         default: begin
            c_in.ddl = time_lt(adv, up_data.now) ? nadv : adv;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_rdy) begin
         c_valid_ff <= up_valid;
      end
      if (c_rdy) begin
         c_ff <= c_in;
      end
   end

endmodule

### design/tdcr_round.sv
module tdcr_round (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  tdcr_pkg::sched_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output tdcr_pkg::fin_type   dn_data
);
   import tdcr_pkg::*;

   sched_type   d_ff, e_ff;
   logic [9:0]  d_ms_ff;
   logic [10:0] e_ms_in, e_ms_ff;
   fin_type     f_in, f_ff;
   logic        d_valid_ff, e_valid_ff, f_valid_ff;
   logic        d_rdy, e_rdy, f_rdy;

   logic [9:0]  ms, lo, rem50, rem100;
   logic [10:0] hi, hi_sum, base, stepv, half, mid, step_pick;
   logic [10:0] b25, b50, b100, b200, b250, b500;
   logic [8:0]  h2;
   logic [7:0]  h4;
   time_type    t;

   assign d_rdy    = !d_valid_ff || e_rdy;
   assign e_rdy    = !e_valid_ff || f_rdy;
   assign f_rdy    = !f_valid_ff || dn_ready;
   assign up_ready = d_rdy;
   assign dn_valid = f_valid_ff;
   assign dn_data  = f_ff;

   // stage d: millisecond within the second
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_rdy) begin
         d_valid_ff <= up_valid;
      end
      if (d_rdy) begin
         d_ff    <= up_data;
         d_ms_ff <= div1000_u20(up_data.ddl.u);
      end
   end

   // stage e: snap the millisecond to a preferred boundary
   always_comb begin
      ms     = d_ms_ff;
      lo     = (ms > d_ff.slack) ? ms - d_ff.slack : 10'd0;
      hi_sum = 11'(ms) + 11'(d_ff.slack);
      hi     = (hi_sum > MS_PER_SEC) ? MS_PER_SEC : hi_sum;
      b25    = 11'(quot_u10(ms, 16'(RCP_25_U10))) * 11'd25;
      b50    = 11'(quot_u10(ms, 16'(RCP_50_U10))) * 11'd50;
      b100   = 11'(quot_u10(ms, 16'(RCP_100_U10))) * 11'd100;
      b200   = 11'(quot_u10(ms, 16'(RCP_200_U10))) * 11'd200;
      b250   = 11'(quot_u10(ms, 16'(RCP_250_U10))) * 11'd250;
      b500   = 11'(quot_u10(ms, 16'(RCP_500_U10))) * 11'd500;
      rem50  = ms - b50[9:0];
      rem100 = ms - b100[9:0];
      case (d_ff.step)
         STEP_50:  begin base = b50;  stepv = 11'd50;  end
         STEP_100: begin base = b100; stepv = 11'd100; end
         STEP_200: begin base = b200; stepv = 11'd200; end
         STEP_250: begin base = b250; stepv = 11'd250; end
         STEP_500: begin base = b500; stepv = 11'd500; end
         default:  begin base = b25;  stepv = 11'd25;  end
      endcase
      half = stepv >> 1;
      mid  = base + half;
      if (11'(ms) < mid) begin
         step_pick = (base > 11'(lo)) ? base : 11'(lo);
      end else begin
         step_pick = ((base + stepv) < hi) ? base + stepv : hi;
      end
      h2 = ms[9:1] | {8'd0, rem50 >= 10'd25};
      h4 = ms[9:2] | {7'd0, rem100 >= 10'd50};
      case (d_ff.rmode)
         RND_TWO:  e_ms_in = {1'b0, h2, 1'b0};
         RND_FOUR: e_ms_in = {1'b0, h4, 2'b00};
         default: begin
            if (lo == 10'd0) begin
               e_ms_in = 11'd0;
            end else if (hi == MS_PER_SEC) begin
               e_ms_in = MS_PER_SEC;
            end else if (d_ff.rmode == RND_SPLIT) begin
               e_ms_in = (11'(ms) >= HALF_MS_PER_SEC) ? hi : 11'(lo);
            end else begin
               e_ms_in = step_pick;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (e_rdy) begin
         e_valid_ff <= d_valid_ff;
      end
      if (e_rdy) begin
         e_ff    <= d_ff;
         e_ms_ff <= e_ms_in;
      end
   end

   // stage f: for coarse timers, apply the rounded millisecond, step once more if it fell behind
   always_comb begin
      t = e_ff.ddl;
      if (e_ff.kind == KIND_COARSE) begin
         if (e_ms_ff == MS_PER_SEC) begin
            t.s = t.s + SEC_W'(1);
            t.u = 20'd0;
         end else begin
            t.u = 20'(e_ms_ff) * 20'd1000;
         end
         if (time_lt(t, e_ff.now)) begin
            t = time_add(t, e_ff.q, e_ff.r);
         end
      end
      f_in.now = e_ff.now;
      f_in.ddl = t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (f_rdy) begin
         f_valid_ff <= e_valid_ff;
      end
      if (f_rdy) begin
         f_ff <= f_in;
      end
   end

endmodule

### design/tdcr_delay.sv
module tdcr_delay (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  tdcr_pkg::fin_type up_data,
   output logic              dn_valid,
   input  logic              dn_ready,
   output logic [31:0]       next_sec,
   output logic [19:0]       next_usec,
   output logic [31:0]       delay_ms
);
   import tdcr_pkg::*;

   logic signed [SEC_W:0] ds_in, g_ds_ff;
   logic signed [20:0]    du;
   logic [20:0]           mag;
   logic                  g_neg_ff, g_valid_ff, g_rdy;
   logic [9:0]            g_dq_ff;
   logic [31:0]           g_sec_ff;
   logic [19:0]           g_usec_ff;

   logic signed [46:0] dl, frac;
   logic [31:0]        delay_in;
   logic               h_valid_ff, h_rdy;
   logic [31:0]        sec_ff, delay_ff;
   logic [19:0]        usec_ff;

   assign g_rdy     = !g_valid_ff || h_rdy;
   assign h_rdy     = !h_valid_ff || dn_ready;
   assign up_ready  = g_rdy;
   assign dn_valid  = h_valid_ff;
   assign next_sec  = sec_ff;
   assign next_usec = usec_ff;
   assign delay_ms  = delay_ff;

   // stage g: second and microsecond differences, ms of the latter
   always_comb begin
      ds_in = $signed({1'b0, up_data.ddl.s}) - $signed({1'b0, up_data.now.s});
      du    = $signed({1'b0, up_data.ddl.u}) - $signed({1'b0, up_data.now.u});
      mag   = du[20] ? 21'(-du) : 21'(du);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (g_rdy) begin
         g_valid_ff <= up_valid;
      end
      if (g_rdy) begin
         g_ds_ff   <= ds_in;
         g_neg_ff  <= du[20];
         g_dq_ff   <= div1000_u20(mag[19:0]);
         g_sec_ff  <= up_data.ddl.s[SEC_BITS-1:0];
         g_usec_ff <= up_data.ddl.u;
      end
   end

   // stage h: total in ms, clamped at zero and saturated
   always_comb begin
      frac = $signed({37'd0, g_dq_ff});
      dl   = 47'(g_ds_ff) * 47'sd1000 + (g_neg_ff ? -frac : frac);
      if (dl < 47'sd0) begin
         delay_in = 32'd0;
      end else if (dl > 47'sd4294967295) begin
         delay_in = 32'hFFFF_FFFF;
      end else begin
         delay_in = dl[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (h_rdy) begin
         h_valid_ff <= g_valid_ff;
      end
      if (h_rdy) begin
         sec_ff   <= g_sec_ff;
         usec_ff  <= g_usec_ff;
         delay_ff <= delay_in;
      end
   end

endmodule

### design/timer_deadline_coarse_rounding.sv
// throughput: one transaction per cycle while rsp_stall is low, every stage holds its own valid bit
// the 8 stages are prep (2), interval step (1), rounding (3) and delay (2)
// a stalled output only backs up the stages behind it as they fill
// reset (synchronous) clears the valid bits; payload registers are not reset
module timer_deadline_coarse_rounding (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [30:0] req_interval_ms,
   input  logic [31:0] req_now_sec,
   input  logic [19:0] req_now_usec,
   input  logic [31:0] req_prev_sec,
   input  logic [19:0] req_prev_usec,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_sec,
   output logic [19:0] rsp_next_usec,
   output logic [31:0] rsp_delay_ms
);
   import tdcr_pkg::*;

   req_type   req;
   sched_type prep_data, step_data;
   fin_type   round_data;
   logic      prep_ready, prep_valid, step_ready, step_valid;
   logic      round_ready, round_valid, delay_ready;

   // input transaction
   always_comb begin
      req.kind   = kind_type'(req_mode);
      req.ivl    = req_interval_ms;
      req.now_s  = req_now_sec;
      req.now_u  = req_now_usec;
      req.prev_s = req_prev_sec;
      req.prev_u = req_prev_usec;
   end

   assign req_stall = !prep_ready;

   tdcr_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (prep_ready),
      .up_data  (req),
      .dn_valid (prep_valid),
      .dn_ready (step_ready),
      .dn_data  (prep_data)
   );

   tdcr_step u_step (
      .clock    (clock),
      .reset    (reset),
      .up_valid (prep_valid),
      .up_ready (step_ready),
      .up_data  (prep_data),
      .dn_valid (step_valid),
      .dn_ready (round_ready),
      .dn_data  (step_data)
   );

   tdcr_round u_round (
      .clock    (clock),
      .reset    (reset),
      .up_valid (step_valid),
      .up_ready (round_ready),
      .up_data  (step_data),
      .dn_valid (round_valid),
      .dn_ready (delay_ready),
      .dn_data  (round_data)
   );

   tdcr_delay u_delay (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (round_valid),
      .up_ready  (delay_ready),
      .up_data   (round_data),
      .dn_valid  (rsp_valid),
      .dn_ready  (!rsp_stall),
      .next_sec  (rsp_next_sec),
      .next_usec (rsp_next_usec),
      .delay_ms  (rsp_delay_ms)
   );

   // checks
`include "timer_deadline_coarse_rounding_assert.svh"
   `TDCR_CHECK_NOW(usec_in_range, rsp_valid, rsp_next_usec <= USEC_MAX, "usec out of range")
   `TDCR_CHECK_NOW(stall_from_output, req_stall, rsp_valid && rsp_stall, "stall without full output")
   `TDCR_CHECK_NEXT(reset_empties_output, reset, !rsp_valid, "output valid after reset")
   `TDCR_CHECK_NEXT(reset_frees_input, reset, !req_stall, "input stalled after reset")

endmodule

### sim/tb.sv
module tb;
   import tdcr_pkg::*;

   typedef struct {
      kind_type    mode;
      logic [30:0] interval_ms;
      logic [31:0] now_sec;
      logic [19:0] now_usec;
      logic [31:0] prev_sec;
      logic [19:0] prev_usec;
      bit          wait_drain;
   } sched_req_type;

   typedef struct {
      logic [31:0] next_sec;
      logic [19:0] next_usec;
      logic [31:0] delay_ms;
   } deadline_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [30:0] req_interval_ms;
   logic [31:0] req_now_sec;
   logic [19:0] req_now_usec;
   logic [31:0] req_prev_sec;
   logic [19:0] req_prev_usec;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_next_sec;
   logic [19:0] rsp_next_usec;
   logic [31:0] rsp_delay_ms;

   sched_req_type pending_reqs[$];
   deadline_type  expected_deadlines[$];
   int            sent_count = 0;
   int            checked_count = 0;
   int            error_count = 0;
   int            hold_cycles;
   bit            long_hold_done;

   timer_deadline_coarse_rounding u_top (.*);

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // idle percentages per phase of the random part
   function automatic int sender_idle_pct(int n);
      if (n < 270) return 0;
      if (n < 500) return 59;
      if (n < 750) return 0;
      return 8;
   endfunction

   function automatic int receiver_stall_pct(int n);
      if (n < 500) return 0;
      if (n < 750) return 59;
      return 8;
   endfunction

   // millisecond within the second snapped to preferred boundaries
   function automatic longint snap_ms(longint ivl, longint ms);
      longint slack, lo, hi, step, base, mid, q;
      slack = ivl / 20;
      if (ivl < 100 && (ivl % 25) != 0) begin
         if (ivl < 50) return ((ms >> 1) | (((ms % 50) >= 25) ? 1 : 0)) << 1;
         return ((ms >> 2) | (((ms % 100) >= 50) ? 1 : 0)) << 2;
      end
      lo = (ms - slack < 0) ? 0 : ms - slack;
      hi = (ms + slack > 1000) ? 1000 : ms + slack;
      if (lo == 0) return 0;
      if (hi == 1000) return 1000;
      if ((ivl % 500) == 0) begin
         if (ivl >= 5000) return (ms >= 500) ? hi : lo;
         step = 500;
      end else if ((ivl % 50) == 0) begin
         q = ivl / 50;
         if ((q % 4) == 0) step = 200;
         else if ((q % 2) == 0) step = 100;
         else if ((q % 5) == 0) step = 250;
         else step = 50;
      end else begin
         step = 25;
      end
      base = (ms / step) * step;
      mid = base + step / 2;
      if (ms < mid) return (base > lo) ? base : lo;
      return (base + step < hi) ? base + step : hi;
   endfunction

   // next deadline and delay for one reschedule request
   function automatic deadline_type next_deadline(sched_req_type r);
      kind_type     kind;
      longint       ivl, ns, nu, ws, wu, ahead, delay, ms;
      deadline_type d;
      kind = r.mode;
      ivl = r.interval_ms;
      ns = r.now_sec;
      nu = (r.now_usec > USEC_MAX) ? 999999 : r.now_usec;
      ws = r.prev_sec;
      wu = (r.prev_usec > USEC_MAX) ? 999999 : r.prev_usec;
      if (kind == KIND_COARSE || kind == KIND_COARSE_ALT) begin
         if (ivl >= 20000) kind = KIND_VCOARSE;
         else if (ivl <= 20) kind = KIND_PRECISE;
         else kind = KIND_COARSE;
      end
      // resync a deadline that is too far ahead
      if (ivl != 0) begin
         ahead = (ws * 1000 + wu / 1000) - (ns * 1000 + nu / 1000);
         if ((ivl < 1000 && ahead > 1500) || (ivl >= 1000 && 5 * ahead > 6 * ivl)) begin
            ws = ns;
            wu = nu;
         end
      end
      if (kind == KIND_VCOARSE) begin
         if (wu >= 500000) ws += 1;
         wu = 0;
         ws += ivl / 1000;
         if (ws <= ns) ws = ns + ivl / 1000;
      end else if (kind == KIND_PRECISE && ivl == 0) begin
         ws = ns;
         wu = nu;
      end else begin
         ws += ivl / 1000;
         wu += (ivl % 1000) * 1000;
         if (wu > 999999) begin ws += 1; wu -= 1000000; end
         if (ws < ns || (ws == ns && wu < nu)) begin
            ws = ns + ivl / 1000;
            wu = nu + (ivl % 1000) * 1000;
            if (wu > 999999) begin ws += 1; wu -= 1000000; end
         end
         if (kind == KIND_COARSE) begin
            ms = snap_ms(ivl, wu / 1000);
            if (ms == 1000) begin
               ws += 1;
               wu = 0;
            end else begin
               wu = ms * 1000;
            end
            if (ws < ns || (ws == ns && wu < nu)) begin
               ws += ivl / 1000;
               wu += (ivl % 1000) * 1000;
               if (wu > 999999) begin ws += 1; wu -= 1000000; end
            end
         end
      end
      delay = (ws - ns) * 1000 + (wu - nu) / 1000;
      if (delay < 0) delay = 0;
      if (delay > 64'hFFFF_FFFF) delay = 64'hFFFF_FFFF;
      d.next_sec = ws[31:0];
      d.next_usec = wu[19:0];
      d.delay_ms = delay[31:0];
      return d;
   endfunction

   function automatic sched_req_type make_req(kind_type m, longint ivl, longint ns, longint nu,
                                              longint ps, longint pu);
      sched_req_type r;
      r.mode = m;
      r.interval_ms = ivl[30:0];
      r.now_sec = ns[31:0];
      r.now_usec = nu[19:0];
      r.prev_sec = ps[31:0];
      r.prev_usec = pu[19:0];
      r.wait_drain = 1'b0;
      return r;
   endfunction

   // random request, mostly prev near now so every branch gets exercised
   function automatic sched_req_type random_req();
      sched_req_type r;
      longint        ivl, ns, nu, off, pabs;
      int            pick;
      pick = int'($urandom_range(9));
      case (pick)
         0: ivl = $urandom & 32'h7FFF_FFFF;
         1: ivl = $urandom_range(0, 20);
         2: ivl = $urandom_range(21, 99);
         3: ivl = 25 * $urandom_range(1, 80);
         4: ivl = 50 * $urandom_range(1, 400);
         5: ivl = $urandom_range(20000, 200000);
         default: ivl = $urandom_range(0, 30000);
      endcase
      ns = ($urandom_range(7) == 0) ? 64'hFFFF_FFFF - $urandom_range(3) : $urandom;
      nu = ($urandom_range(15) == 0) ? $urandom_range(20'hFFFFF) : $urandom_range(999999);
      r = make_req(kind_type'($urandom_range(3)), ivl, ns, nu, 0, 0);
      if ($urandom_range(5) == 0) begin
         r.prev_sec = $urandom;
         r.prev_usec = ($urandom_range(15) == 0) ? 20'($urandom_range(20'hFFFFF)) :
                                                   20'($urandom_range(999999));
      end else begin
         off = longint'($urandom_range(0, 4000)) - 2000;
         if ($urandom_range(1)) off += ivl * $urandom_range(0, 3) / 2;
         pabs = ns * 1000 + nu / 1000 + off;
         if (pabs < 0) pabs = 0;
         r.prev_sec = 32'(pabs / 1000);
         r.prev_usec = 20'((pabs % 1000) * 1000 + $urandom_range(999));
      end
      return r;
   endfunction

   // sender: one transaction offered from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_mode <= '0;
         req_interval_ms <= '0;
         req_now_sec <= '0;
         req_now_usec <= '0;
         req_prev_sec <= '0;
         req_prev_usec <= '0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() > 0 &&
             !(pending_reqs[0].wait_drain && (expected_deadlines.size() != 0 || req_valid)) &&
             $urandom_range(99) >= sender_idle_pct(sent_count)) begin
            req_valid <= 1'b1;
            req_mode <= pending_reqs[0].mode;
            req_interval_ms <= pending_reqs[0].interval_ms;
            req_now_sec <= pending_reqs[0].now_sec;
            req_now_usec <= pending_reqs[0].now_usec;
            req_prev_sec <= pending_reqs[0].prev_sec;
            req_prev_usec <= pending_reqs[0].prev_usec;
            void'(pending_reqs.pop_front());
            sent_count <= sent_count + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off to back up the pipeline
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles <= 0;
         long_hold_done <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (sent_count >= 600 && !long_hold_done) begin
         hold_cycles <= 300;
         long_hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct(sent_count));
      end
   end

   // monitor: predict on input transaction, check on result transaction
   always @(posedge clock) begin
      sched_req_type r;
      deadline_type  e;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            r = make_req(kind_type'(req_mode), req_interval_ms, req_now_sec, req_now_usec,
                         req_prev_sec, req_prev_usec);
            expected_deadlines.push_back(next_deadline(r));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_deadlines.size() == 0) begin
               $error("unexpected result transaction");
               error_count++;
            end else begin
               e = expected_deadlines.pop_front();
               checked_count++;
               if (rsp_next_sec !== e.next_sec) begin
                  $error("next_sec expected %0d actual %0d", e.next_sec, rsp_next_sec);
                  error_count++;
               end
               if (rsp_next_usec !== e.next_usec) begin
                  $error("next_usec expected %0d actual %0d", e.next_usec, rsp_next_usec);
                  error_count++;
               end
               if (rsp_delay_ms !== e.delay_ms) begin
                  $error("delay_ms expected %0d actual %0d", e.delay_ms, rsp_delay_ms);
                  error_count++;
               end
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      sched_req_type r;
      // directed corners
      pending_reqs.push_back(make_req(KIND_PRECISE, 0, 100, 250000, 90, 0));
      pending_reqs.push_back(make_req(KIND_COARSE, 0, 100, 250000, 100, 0));
      pending_reqs.push_back(make_req(KIND_VCOARSE, 0, 100, 700000, 100, 600000));
      pending_reqs.push_back(make_req(KIND_COARSE_ALT, 30000, 100, 0, 101, 400000));
      pending_reqs.push_back(make_req(KIND_COARSE, 20, 5, 999999, 5, 990000));
      pending_reqs.push_back(make_req(KIND_COARSE, 21, 5, 123000, 5, 110000));
      pending_reqs.push_back(make_req(KIND_COARSE, 19999, 7, 456000, 8, 0));
      pending_reqs.push_back(make_req(KIND_COARSE, 20000, 7, 456000, 8, 0));
      pending_reqs.push_back(make_req(KIND_PRECISE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 999999,
                                      32'hFFFF_FFFF, 999999));
      pending_reqs.push_back(make_req(KIND_VCOARSE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
      pending_reqs.push_back(make_req(KIND_PRECISE, 300, 50, 20'hFFFFF, 50, 20'hFFFFF));
      pending_reqs.push_back(make_req(KIND_PRECISE, 300, 50, 0, 60, 0));
      pending_reqs.push_back(make_req(KIND_PRECISE, 2000, 50, 0, 52, 500000));
      pending_reqs.push_back(make_req(KIND_PRECISE, 1000, 50, 0, 10, 0));
      pending_reqs.push_back(make_req(KIND_COARSE, 30, 9, 0, 9, 337000));
      pending_reqs.push_back(make_req(KIND_COARSE, 70, 9, 0, 9, 561000));
      pending_reqs.push_back(make_req(KIND_COARSE, 75, 9, 0, 9, 561000));
      pending_reqs.push_back(make_req(KIND_COARSE, 150, 9, 0, 9, 377000));
      pending_reqs.push_back(make_req(KIND_COARSE, 200, 9, 0, 9, 377000));
      pending_reqs.push_back(make_req(KIND_COARSE, 250, 9, 0, 9, 633000));
      pending_reqs.push_back(make_req(KIND_COARSE, 400, 9, 0, 9, 133000));
      pending_reqs.push_back(make_req(KIND_COARSE, 1500, 9, 0, 9, 640000));
      pending_reqs.push_back(make_req(KIND_COARSE, 5000, 9, 0, 9, 620000));
      pending_reqs.push_back(make_req(KIND_COARSE, 1234, 9, 0, 9, 980000));
      pending_reqs.push_back(make_req(KIND_COARSE, 60, 0, 0, 32'hFFFF_FFFF, 0));
      // random part, with drain points
      for (int i = 0; i < 950; i++) begin
         r = random_req();
         if (i == 0 || i == 400 || i == 820) r.wait_drain = 1'b1;
         pending_reqs.push_back(r);
      end
      @(negedge reset);
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_deadlines.size() == 0);
      repeat (20) @(posedge clock);
      $display("checked %0d deadline results over precise, coarse and very coarse timers,",
               checked_count);
      $display("with resync, rounding steps, clamping and sender/receiver stall phases");
      if (error_count == 0 && expected_deadlines.size() == 0)
         $display("timer_deadline_coarse_rounding: match");
      else
         $display("timer_deadline_coarse_rounding: mismatch");
      $finish;
   end

   // timeout guard
   initial begin
      #5000000;
      $display("timer_deadline_coarse_rounding: mismatch");
      $finish;
   end

endmodule
